// ----- design/lkec_pkg.sv -----
`default_nettype none
package lkec_pkg;

	localparam int unsigned ENTRIES_DEF    = 8;
	localparam int unsigned COUNT_BITS_DEF = 16;
	localparam int unsigned KEY_W          = 48;
	localparam int unsigned IDX_OUT_W      = 3;
	localparam int unsigned CNT_OUT_W      = 16;
	localparam int unsigned QUEUE_DEPTH    = 2;

	typedef struct packed {
		logic [15:0] key_x;
		logic [15:0] key_y;
		logic [15:0] key_z;
	} req_t;

	typedef struct packed {
		logic                 hit;
		logic [IDX_OUT_W-1:0] entry_index;
		logic [CNT_OUT_W-1:0] use_count;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_UPD  = 3'b100
	} back_state_t;

endpackage
`default_nettype wire

// ----- design/lkec_front.sv -----
`default_nettype none
module lkec_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire lkec_pkg::req_t req,
	output logic               head_valid,
	output lkec_pkg::req_t     head,
	input  wire logic          head_pop
);

	localparam int unsigned DEPTH = lkec_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(DEPTH + 1);

	lkec_pkg::req_t    slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              push;
	logic              pop;

	assign req_ready  = (fill_q != FILL_W'(DEPTH));
	assign head_valid = (fill_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign push       = req_valid && req_ready;
	assign pop        = head_pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/lkec_back.sv -----
`default_nettype none
module lkec_back #(
	parameter int unsigned ENTRIES    = lkec_pkg::ENTRIES_DEF,
	parameter int unsigned COUNT_BITS = lkec_pkg::COUNT_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           head_valid,
	input  wire lkec_pkg::req_t head,
	output logic                head_pop,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output lkec_pkg::rsp_t      rsp
);

	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CTR_W = $clog2(ENTRIES + 1);
	localparam int unsigned KEY_W = lkec_pkg::KEY_W;

	// entry storage
	logic [KEY_W-1:0]      key_mem [ENTRIES];
	logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];
	logic [ENTRIES-1:0]    valid_q;

	lkec_pkg::back_state_t state_q;
	logic [KEY_W-1:0]      key_q;
	logic [CTR_W-1:0]      rd_idx_q;
	logic                  cmp_vld_s1;
	logic [IDX_W-1:0]      cmp_idx_s1;
	logic [KEY_W-1:0]      key_rd_s1;
	logic [COUNT_BITS-1:0] cnt_rd_s1;
	logic [IDX_W-1:0]      best_idx_q;
	logic [COUNT_BITS-1:0] best_cnt_q;
	logic                  hit_q;
	logic [IDX_W-1:0]      sel_idx_q;
	logic [COUNT_BITS-1:0] sel_cnt_q;
	logic                  rsp_valid_q;
	lkec_pkg::rsp_t        rsp_q;

	logic                  start;
	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	logic                  ent_valid;
	logic                  match;
	logic [COUNT_BITS-1:0] eff_cnt;
	logic                  take;
	logic                  last;
	logic [IDX_W-1:0]      vic_idx;
	logic                  out_free;
	logic                  commit;
	logic [COUNT_BITS-1:0] upd_cnt;

	assign start    = (state_q == lkec_pkg::ST_IDLE) && head_valid;
	assign head_pop = start;
	assign rd_addr  = (state_q == lkec_pkg::ST_IDLE) ? '0 : rd_idx_q[IDX_W-1:0];
	assign rd_en    = start
		|| ((state_q == lkec_pkg::ST_SCAN) && (rd_idx_q < CTR_W'(ENTRIES)));

	// compare stage: entry cmp_idx_s1 against the request key
	assign ent_valid = valid_q[cmp_idx_s1];
	assign match     = ent_valid && (key_rd_s1 == key_q);
	assign eff_cnt   = ent_valid ? cnt_rd_s1 : '0;
	assign take      = (cmp_idx_s1 == '0) || (eff_cnt < best_cnt_q);
	assign last      = (cmp_idx_s1 == IDX_W'(ENTRIES - 1));
	assign vic_idx   = take ? cmp_idx_s1 : best_idx_q;

	assign out_free = !rsp_valid_q || rsp_ready;
	assign commit   = (state_q == lkec_pkg::ST_UPD) && out_free;
	assign upd_cnt  = hit_q ? ((sel_cnt_q == '1) ? sel_cnt_q : sel_cnt_q + COUNT_BITS'(1))
	                        : COUNT_BITS'(1);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			key_rd_s1 <= key_mem[rd_addr];
			cnt_rd_s1 <= cnt_mem[rd_addr];
		end
		if (commit) begin
			cnt_mem[sel_idx_q] <= upd_cnt;
			if (!hit_q) begin
				key_mem[sel_idx_q] <= key_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_addr;
		if (start) begin
			key_q <= head;
		end
		if ((state_q == lkec_pkg::ST_SCAN) && cmp_vld_s1) begin
			if (match) begin
				sel_idx_q <= cmp_idx_s1;
				sel_cnt_q <= cnt_rd_s1;
			end else begin
				if (take) begin
					best_idx_q <= cmp_idx_s1;
					best_cnt_q <= eff_cnt;
				end
				if (last) begin
					sel_idx_q <= vic_idx;
					sel_cnt_q <= '0;
				end
			end
		end
		if (commit) begin
			rsp_q.hit         <= hit_q;
			rsp_q.entry_index <= lkec_pkg::IDX_OUT_W'(sel_idx_q);
			rsp_q.use_count   <= lkec_pkg::CNT_OUT_W'(upd_cnt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lkec_pkg::ST_IDLE;
			rd_idx_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= rd_en;
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				lkec_pkg::ST_IDLE: begin
					if (start) begin
						rd_idx_q <= CTR_W'(1);
						state_q  <= lkec_pkg::ST_SCAN;
					end
				end
				lkec_pkg::ST_SCAN: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CTR_W'(1);
					end
					if (cmp_vld_s1) begin
						if (match) begin
							hit_q   <= 1'b1;
							state_q <= lkec_pkg::ST_UPD;
						end else if (last) begin
							hit_q   <= 1'b0;
							state_q <= lkec_pkg::ST_UPD;
						end
					end
				end
				lkec_pkg::ST_UPD: begin
					// hold until the output register can take the word
					if (commit) begin
						valid_q[sel_idx_q] <= 1'b1;
						state_q            <= lkec_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= lkec_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- design/lfu_keyed_entry_cache_unit.sv -----
`default_nettype none
// LFU keyed entry cache. Each request word carries a 48-bit key (key_x, key_y,
// key_z) and returns one response word: hit, the index of the hit or newly
// filled entry, and that entry's use counter after the access. A hit on a
// valid entry raises its counter by one, saturating at all ones; a miss
// replaces the lowest-indexed entry with the smallest counter (invalid entries
// count as zero) and sets its counter to one. Requests land in a two-word
// input queue; the lookup engine then reads the key and counter memories one
// entry per cycle, stopping at the first hit or after the last entry. The
// result sits in an output register, so the queue keeps accepting until its
// two words are full while a response waits. entry_index carries the low 3
// bits of the index and use_count the low 16 bits of the counter. All entries
// are invalid after reset; no clearing pass is needed.
module lfu_keyed_entry_cache_unit #(
	parameter int unsigned ENTRIES    = lkec_pkg::ENTRIES_DEF,
	parameter int unsigned COUNT_BITS = lkec_pkg::COUNT_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire lkec_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output lkec_pkg::rsp_t      rsp
);

	logic           head_valid;
	lkec_pkg::req_t head;
	logic           head_pop;

	lkec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop)
	);

	lkec_back #(
		.ENTRIES    (ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule
`default_nettype wire
